[sv/sms_pkg.sv]
`default_nettype none

package sms_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SID_W    = 2;

   // operation codes carried in req_tuser[0]
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // result status codes carried in rsp_tuser
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP_HEAD,
      ST_POP_SLOT
   } fsm_state_type;

endpackage

`default_nettype wire

[sv/shared_pool_multi_stack_core.sv]
`default_nettype none
// Several LIFO stacks that share one pool of value slots through a linked free list.
// Input channel (req_*): one word per operation. req_tuser carries the command
// (push or pop) and the stack number; req_tdata carries the value to push.
// Result channel (rsp_*): exactly one word per operation, in order. rsp_tuser
// carries the status (ok, pool full, stack empty); rsp_tdata the popped value,
// zero for every push and every failed pop.
// Operation flow: a push reads the free slot link and the stack head, then writes
// back; a pop makes two dependent memory reads (stack head, then the slot it
// points at). A pop from an empty stack ends after the head read. One operation
// is in flight at a time; a new word is taken whenever the engine is idle, even
// while the previous result still sits in the output register.
// Reset: synchronous, active high. All stacks come up empty and the free list
// chains every slot in order at once; a fill mark stands in for a clearing pass.
// Stall: while the receiver holds rsp_tready low with a result pending, the next
// operation holds in its final cycle with no memory write until the register frees.
module shared_pool_multi_stack_core
   import sms_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int NUM_SLOTS  = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [7:0]         req_tuser,   // [0] cmd, [2:1] stack_id, [7:3] zero
   input  wire logic [VALUE_W-1:0] req_tdata,   // [31:0] push_value
   output      logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   output      logic [7:0]         rsp_tuser,   // [1:0] status, [7:2] zero
   output      logic [VALUE_W-1:0] rsp_tdata    // [31:0] pop_value
);

   localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;   // slot address
   localparam int LW = $clog2(NUM_SLOTS + 1);                      // link, holds null
   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;  // stack index
   localparam int DW = LW + VALUE_W;                               // slot word
   localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);

   // slot word: {link, value}
   logic [DW-1:0] slot_mem [NUM_SLOTS];
   logic [LW-1:0] head_mem [NUM_STACKS];

   fsm_state_type state_ff, state_in;

   logic [SW-1:0]      sid_ff;
   logic               sid_ok_ff;
   logic [VALUE_W-1:0] val_ff;

   logic [LW-1:0]         free_head_ff, free_head_in;
   logic [LW-1:0]         fill_ff, fill_in;     // slots at or above fill were never linked
   logic [NUM_STACKS-1:0] head_vld_ff;
   logic [LW-1:0]         head_q_ff;
   logic                  head_qv_ff;
   logic [DW-1:0]         slot_q_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               out_free;
   logic               req_cmd;
   logic [SID_W-1:0]   req_sid;
   logic [SW-1:0]      req_sid_idx;
   logic               req_sid_ok;
   logic [LW-1:0]      head_ptr;
   logic               pop_has;
   logic               push_ok;
   logic               fresh_slot;
   logic [LW-1:0]      slot_link;
   logic [VALUE_W-1:0] slot_value;

   logic          slot_rd_en;
   logic [AW-1:0] slot_rd_addr;
   logic          slot_wr_en;
   logic [AW-1:0] slot_wr_addr;
   logic [DW-1:0] slot_wr_data;
   logic          head_wr_en;
   logic [LW-1:0] head_wr_data;
   logic          rsp_load;

   assign req_cmd     = req_tuser[0];
   assign req_sid     = req_tuser[SID_W:1];
   assign req_sid_idx = SW'(req_sid);
   assign req_sid_ok  = (32'(req_sid) < 32'(NUM_STACKS));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // an unwritten head entry reads as null
   assign head_ptr   = head_qv_ff ? head_q_ff : NULL_LINK;
   assign pop_has    = sid_ok_ff && (head_ptr != NULL_LINK);
   assign push_ok    = sid_ok_ff && (free_head_ff != NULL_LINK);
   assign fresh_slot = (free_head_ff >= fill_ff);
   assign slot_link  = slot_q_ff[DW-1:VALUE_W];
   assign slot_value = slot_q_ff[VALUE_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_cmd == CMD_POP) ? ST_POP_HEAD : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_HEAD: begin
            if (pop_has) begin
               state_in = ST_POP_SLOT;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_SLOT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      slot_rd_en    = 1'b0;
      slot_rd_addr  = free_head_ff[AW-1:0];
      slot_wr_en    = 1'b0;
      slot_wr_addr  = free_head_ff[AW-1:0];
      slot_wr_data  = {head_ptr, val_ff};
      head_wr_en    = 1'b0;
      head_wr_data  = free_head_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_data_in   = '0;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            // fetch the link of the free head for a push
            slot_rd_en = req_accept;
         end
         ST_PUSH: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = push_ok ? STATUS_OK : STATUS_FULL;
               if (push_ok) begin
                  slot_wr_en = 1'b1;
                  head_wr_en = 1'b1;
                  // a never-linked slot still points at its successor
                  if (fresh_slot) begin
                     free_head_in = free_head_ff + LW'(1);
                     fill_in      = fill_ff + LW'(1);
                  end else begin
                     free_head_in = slot_link;
                  end
               end
            end
         end
         ST_POP_HEAD: begin
            if (pop_has) begin
               slot_rd_en   = 1'b1;
               slot_rd_addr = head_ptr[AW-1:0];
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_EMPTY;
            end
         end
         ST_POP_SLOT: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_data_in   = slot_value;
               slot_wr_en    = 1'b1;
               slot_wr_addr  = head_ptr[AW-1:0];
               slot_wr_data  = {free_head_ff, slot_value};
               head_wr_en    = 1'b1;
               head_wr_data  = slot_link;
               free_head_in  = head_ptr;
            end
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         head_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         if (head_wr_en) begin
            head_vld_ff[sid_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // latch the operation and read the stack head on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sid_ff     <= req_sid_idx;
         sid_ok_ff  <= req_sid_ok;
         val_ff     <= req_tdata;
         head_q_ff  <= head_mem[req_sid_idx];
         head_qv_ff <= head_vld_ff[req_sid_idx] && req_sid_ok;
      end
      if (head_wr_en) begin
         head_mem[sid_ff] <= head_wr_data;
      end
   end

   // slot pool
   always_ff @(posedge clock) begin
      if (slot_rd_en) begin
         slot_q_ff <= slot_mem[slot_rd_addr];
      end
      if (slot_wr_en) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {6'd0, rsp_status_ff};
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[dv/sms_result_checker.sv]
`timescale 1ns / 1ps

module sms_result_checker
   import sms_pkg::*;
#(
   parameter int NUM_STACKS = 4,
   parameter int NUM_SLOTS  = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tready,
   input  wire logic [7:0]         req_tuser,   // [0] cmd, [2:1] stack_id, [7:3] zero
   input  wire logic [VALUE_W-1:0] req_tdata,   // [31:0] push_value
   input  wire logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire logic [7:0]         rsp_tuser,   // [1:0] status, [7:2] zero
   input  wire logic [VALUE_W-1:0] rsp_tdata,   // [31:0] pop_value
   output int                      errors,
   output int                      waiting,
   output int                      pushes_stored,
   output int                      pops_returned,
   output int                      full_refusals,
   output int                      empty_refusals
);

   localparam int LINK_W = $clog2(NUM_SLOTS + 1);
   localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(NUM_SLOTS);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
   } stack_result_type;

   logic [VALUE_W-1:0] slot_data [NUM_SLOTS];
   logic [LINK_W-1:0]  slot_next [NUM_SLOTS];
   logic [LINK_W-1:0]  top_slot  [NUM_STACKS];
   logic [LINK_W-1:0]  free_slot;
   stack_result_type   expected_results [$];

   int fail_tally   = 0;
   int stored_tally = 0;
   int popped_tally = 0;
   int full_tally   = 0;
   int empty_tally  = 0;

   function automatic void note_failure(input string what, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
      fail_tally++;
      if (fail_tally <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
   endfunction

   // Apply one stack operation to the shadow pool and return its result.
   function automatic stack_result_type apply_stack_op(input logic cmd,
                                                       input logic [SID_W-1:0] sid,
                                                       input logic [VALUE_W-1:0] value);
      stack_result_type  r;
      logic [LINK_W-1:0] slot;
      logic [ADDR_W-1:0] idx;
      r.status = STATUS_OK;
      r.value  = '0;
      if (cmd == CMD_PUSH) begin
         slot = free_slot;
         idx  = slot[ADDR_W-1:0];
         if (int'(sid) >= NUM_STACKS || slot >= NO_SLOT) begin
            r.status = STATUS_FULL;
         end else begin
            slot_data[idx] = value;
            free_slot      = slot_next[idx];
            slot_next[idx] = top_slot[sid];
            top_slot[sid]  = slot;
         end
      end else begin
         slot = (int'(sid) < NUM_STACKS) ? top_slot[sid] : NO_SLOT;
         idx  = slot[ADDR_W-1:0];
         if (slot >= NO_SLOT) begin
            r.status = STATUS_EMPTY;
         end else begin
            top_slot[sid]  = slot_next[idx];
            slot_next[idx] = free_slot;
            free_slot      = slot;
            r.value        = slot_data[idx];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      stack_result_type want;
      int               i;
      if (reset) begin
         for (i = 0; i < NUM_SLOTS; i++) begin
            slot_next[i] = (i == NUM_SLOTS - 1) ? NO_SLOT : LINK_W'(i + 1);
         end
         for (i = 0; i < NUM_STACKS; i++) begin
            top_slot[i] = NO_SLOT;
         end
         free_slot = '0;
         expected_results.delete();
      end else begin
         // retire the older word first; a new request can never be answered at the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               note_failure("unexpected result", '0, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== {{(8 - STATUS_W){1'b0}}, want.status})
                  note_failure("status", VALUE_W'(want.status), VALUE_W'(rsp_tuser));
               if (rsp_tdata !== want.value)
                  note_failure("pop value", want.value, rsp_tdata);
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_stack_op(req_tuser[0], req_tuser[SID_W:1], req_tdata);
            expected_results.push_back(want);
            case (want.status)
               STATUS_FULL:  full_tally++;
               STATUS_EMPTY: empty_tally++;
               default: begin
                  if (req_tuser[0] == CMD_PUSH) stored_tally++;
                  else popped_tally++;
               end
            endcase
         end
      end
      errors         <= fail_tally;
      waiting        <= expected_results.size();
      pushes_stored  <= stored_tally;
      pops_returned  <= popped_tally;
      full_refusals  <= full_tally;
      empty_refusals <= empty_tally;
   end

endmodule

[dv/tb_shared_pool_multi_stack_core.sv]
`timescale 1ns / 1ps

module tb_shared_pool_multi_stack_core;
   import sms_pkg::*;

   localparam int RANDOM_OPS   = 800;
   localparam int IDLE_PHASES  = 4;
   localparam int SEGMENTS     = 4;
   localparam int SEGMENT_OPS  = RANDOM_OPS / (IDLE_PHASES * SEGMENTS);

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tuser  = '0;   // [0] cmd, [2:1] stack_id, [7:3] zero
   logic [VALUE_W-1:0] req_tdata  = '0;   // [31:0] push_value
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tuser;         // [1:0] status, [7:2] zero
   logic [VALUE_W-1:0] rsp_tdata;         // [31:0] pop_value

   // idling odds in percent, changed per phase
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int sent_words      = 0;

   int fail_count;
   int pending_count;
   int stored_count;
   int popped_count;
   int full_count;
   int empty_count;

   shared_pool_multi_stack_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // The checker mirrors the pool and flags every result word that disagrees.
   sms_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tuser      (rsp_tuser),
      .rsp_tdata      (rsp_tdata),
      .errors         (fail_count),
      .waiting        (pending_count),
      .pushes_stored  (stored_count),
      .pops_returned  (popped_count),
      .full_refusals  (full_count),
      .empty_refusals (empty_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Stall the result channel at random; a zero percentage keeps it always ready.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Present one operation word and hold it until the block takes it.
   // Valid only drops when a gap follows, so back-to-back words never toggle it.
   task automatic send_op(input logic cmd, input logic [SID_W-1:0] sid,
                          input logic [VALUE_W-1:0] value);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {5'b0, sid, cmd};
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   // Mostly random values, with the signed extremes, zero and all-ones mixed in.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int               phase;
      int               seg;
      int               k;
      int               push_pct;
      logic [SID_W-1:0] favored;
      logic [SID_W-1:0] sid;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Pop every stack while all are empty.
      for (k = 0; k < 4; k++) send_op(CMD_POP, SID_W'(k), '1);

      // Push the value extremes and alternating patterns across all stacks.
      send_op(CMD_PUSH, 2'd0, 32'h8000_0000);
      send_op(CMD_PUSH, 2'd1, 32'h7FFF_FFFF);
      send_op(CMD_PUSH, 2'd2, 32'h0000_0000);
      send_op(CMD_PUSH, 2'd3, 32'hFFFF_FFFF);
      send_op(CMD_PUSH, 2'd3, 32'h5555_5555);
      send_op(CMD_PUSH, 2'd0, 32'hAAAA_AAAA);

      // Drain in LIFO order, reusing freed slots, then hit an empty stack again.
      send_op(CMD_POP, 2'd3, 32'h1234_5678);
      send_op(CMD_POP, 2'd3, '0);
      send_op(CMD_POP, 2'd0, '0);
      send_op(CMD_PUSH, 2'd1, 32'hDEAD_BEEF);
      send_op(CMD_POP, 2'd0, '0);
      send_op(CMD_POP, 2'd1, '0);
      send_op(CMD_POP, 2'd1, '0);
      send_op(CMD_POP, 2'd2, '0);
      send_op(CMD_POP, 2'd2, '0);

      // Random part: each idling phase runs fill, fill, drain and mixed segments,
      // so the pool reaches full every phase and the favored stack runs dry.
      for (phase = 0; phase < IDLE_PHASES; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
            1:       begin sender_idle_pct = 86; stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  stall_pct = 86; end
            default: begin sender_idle_pct = 38; stall_pct = 38; end
         endcase
         for (seg = 0; seg < SEGMENTS; seg++) begin
            favored  = SID_W'($urandom_range(3));
            push_pct = (seg < 2) ? 85 : ((seg == 2) ? 15 : 50);
            for (k = 0; k < SEGMENT_OPS; k++) begin
               sid = ($urandom_range(99) < 60) ? favored : SID_W'($urandom_range(3));
               send_op(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, sid,
                       pick_value());
            end
         end
      end

      // Release the bus and let the last word land in the checker's queue.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d operations: %0d pushes stored, %0d pops returned,",
               sent_words, stored_count, popped_count);
      $display("%0d pushes refused on a full pool, %0d pops from empty stacks, %0d errors",
               full_count, empty_count, fail_count);
      if (fail_count == 0) begin
         $display("shared_pool_multi_stack_core verification clean");
      end else begin
         $display("shared_pool_multi_stack_core verification failed");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_count);
      $display("shared_pool_multi_stack_core verification failed");
      $finish;
   end

endmodule
